// File: rtl/siocr_pkg.sv
// ----------------------------------------------------------------------------
// siocr_pkg: shared types, constants and tables
// Register map tables, device page defaults and write masks for the
// configuration register space.
// ----------------------------------------------------------------------------
`default_nettype none

package siocr_pkg;

  localparam int LAST_DEVICE = 8;
  localparam int PAGE_COUNT  = LAST_DEVICE + 1;
  localparam int RAM_DEPTH   = PAGE_COUNT * 256;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int DEV_W       = 4;

  // GPIO window registers live in this device page
  localparam logic [DEV_W-1:0] GPIO_DEV = DEV_W'(8);
  localparam logic             GPIO_OK  = (8 <= LAST_DEVICE);

  // configuration register indexes
  localparam logic [1:0] CFG_ALT_MODE = 2'd0;
  localparam logic [1:0] CFG_ALT_PORT = 2'd1;

  // magic index writes
  localparam logic [7:0] KEY_ENTER = 8'h55;
  localparam logic [7:0] KEY_EXIT  = 8'hAA;

  // fixed lock / unlock ports and quirky read ports
  localparam logic [15:0] PORT_LOCK   = 16'h00F9;
  localparam logic [15:0] PORT_UNLOCK = 16'h00FB;
  localparam logic [15:0] PORT_EA     = 16'h00EA;
  localparam logic [15:0] PORT_EB     = 16'h00EB;

  typedef struct packed {
    logic              clear;
    logic [RAM_AW-1:0] clr_addr;
    logic              capture;
    logic              commit;
  } siocr_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] mask;
    logic [7:0] orv;
    logic [7:0] en;
  } dev_wr_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] idx;
    logic [7:0] mask;
  } gpio_map_t;

  // page address of a device register
  function automatic logic [RAM_AW-1:0] dev_addr(input logic [DEV_W-1:0] d,
                                                 input logic [7:0] r);
    dev_addr = RAM_AW'({d, r});
  endfunction

  // reset contents of the device pages
  function automatic logic [7:0] dev_default(input logic [DEV_W-1:0] d,
                                             input logic [7:0] r);
    logic [7:0] v;
    v = 8'h00;
    case (d)
      4'd0: begin
        case (r)
          8'h60: v = 8'h03;
          8'h61: v = 8'hF0;
          8'h70: v = 8'h06;
          8'h74: v = 8'h02;
          8'hF0: v = 8'h0E;
          8'hF2: v = 8'hFF;
          default: v = 8'h00;
        endcase
      end
      4'd3: begin
        case (r)
          8'h60: v = 8'h03;
          8'h61: v = 8'h78;
          8'h70: v = 8'h07;
          8'h74: v = 8'h04;
          8'hF0: v = 8'h3C;
          default: v = 8'h00;
        endcase
      end
      4'd4: begin
        case (r)
          8'h60: v = 8'h03;
          8'h61: v = 8'hF8;
          8'h70: v = 8'h04;
          default: v = 8'h00;
        endcase
      end
      4'd5: begin
        case (r)
          8'h60: v = 8'h02;
          8'h61: v = 8'hF8;
          8'h70: v = 8'h03;
          8'h74: v = 8'h04;
          8'hF1: v = 8'h02;
          8'hF2: v = 8'h03;
          default: v = 8'h00;
        endcase
      end
      4'd7: begin
        case (r)
          8'h61: v = 8'h60;
          8'h70: v = 8'h01;
          default: v = 8'h00;
        endcase
      end
      4'd8: begin
        case (r)
          8'hC0: v = 8'h06;
          8'hC1: v = 8'h03;
          default: v = 8'h00;
        endcase
      end
      default: v = 8'h00;
    endcase
    if (32'(d) > LAST_DEVICE) v = 8'h00;
    dev_default = v;
  endfunction

  // write rules of the device pages: mask, forced bits, activate side effect
  function automatic dev_wr_t dev_wr(input logic [DEV_W-1:0] d, input logic [7:0] r);
    dev_wr_t w;
    w = '{hit: 1'b0, mask: 8'hFF, orv: 8'h00, en: 8'h00};
    case (d)
      4'd0: begin
        if (r inside {8'h30, 8'h60, 8'h61, 8'h70, 8'h74, 8'hF2}) w.hit = 1'b1;
        else if (r == 8'hF0) begin w.hit = 1'b1; w.mask = 8'hEF; end
        else if (r == 8'hF1) begin w.hit = 1'b1; w.mask = 8'hFC; end
        else if (r inside {[8'hF4:8'hF7]}) begin w.hit = 1'b1; w.mask = 8'h5B; end
        if (r == 8'h30) w.en = 8'h01;
      end
      4'd3: begin
        if (r inside {8'h30, 8'h60, 8'h61, 8'h70, 8'h74, 8'hF0}) w.hit = 1'b1;
        else if (r == 8'hF1) begin w.hit = 1'b1; w.mask = 8'h03; end
        if (r == 8'h30) w.en = 8'h08;
      end
      4'd4: begin
        if (r inside {8'h30, 8'h60, 8'h61, 8'h70}) w.hit = 1'b1;
        else if (r == 8'hF0) begin w.hit = 1'b1; w.mask = 8'h83; end
        if (r == 8'h30) w.en = 8'h10;
      end
      4'd5: begin
        if (r inside {8'h30, [8'h60:8'h63], 8'h70, 8'h74, 8'hF2}) w.hit = 1'b1;
        else if (r == 8'hF0) begin w.hit = 1'b1; w.mask = 8'h03; end
        else if (r == 8'hF1) begin w.hit = 1'b1; w.mask = 8'h7F; end
        if (r == 8'h30) w.en = 8'h20;
      end
      4'd7: begin
        if (r inside {8'h30, 8'h70, 8'h72}) w.hit = 1'b1;
        else if (r == 8'hF0) begin w.hit = 1'b1; w.mask = 8'h84; end
      end
      4'd8: begin
        if (r inside {8'h30, 8'hB8, [8'hF1:8'hF3]}) w.hit = 1'b1;
        else if (r inside {8'hB4, 8'hB6}) begin w.hit = 1'b1; w.mask = 8'h9E; end
        else if (r == 8'hB5) begin w.hit = 1'b1; w.mask = 8'hD7; end
        else if (r == 8'hB7) begin w.hit = 1'b1; w.mask = 8'h17; end
        // reserved bits of C0 never change from their reset pattern
        else if (r == 8'hC0) begin w.hit = 1'b1; w.mask = 8'h1B; w.orv = 8'h04; end
        else if (r == 8'hC1) begin w.hit = 1'b1; w.mask = 8'h0F; end
        else if (r == 8'hF4) begin w.hit = 1'b1; w.mask = 8'hEF; end
      end
      default: w.hit = 1'b0;
    endcase
    dev_wr = w;
  endfunction

  // GPIO window index to device page register
  function automatic gpio_map_t gpio_map(input logic [7:0] g);
    gpio_map_t m;
    m = '{hit: 1'b0, idx: 8'hF4, mask: 8'hEF};
    if (g == 8'h03) begin
      m.hit = 1'b1;
    end else if (g inside {[8'h0C:8'h0F]}) begin
      m.hit  = 1'b1;
      m.idx  = 8'hA8 + g;
      m.mask = (g == 8'h0D) ? 8'hD7 : (g == 8'h0F) ? 8'h17 : 8'h9E;
    end
    gpio_map = m;
  endfunction

  function automatic logic [7:0] gpio_base_of(input logic [1:0] s);
    case (s)
      2'd0: gpio_base_of = 8'hE0;
      2'd1: gpio_base_of = 8'hE2;
      2'd2: gpio_base_of = 8'hE4;
      default: gpio_base_of = 8'hEA;
    endcase
  endfunction

  // ECP config-B IRQ field
  function automatic logic [7:0] irq_code(input logic [7:0] irq);
    case (irq)
      8'd5:  irq_code = 8'h38;
      8'd7:  irq_code = 8'h08;
      8'd9:  irq_code = 8'h10;
      8'd10: irq_code = 8'h18;
      8'd11: irq_code = 8'h20;
      8'd14: irq_code = 8'h28;
      8'd15: irq_code = 8'h30;
      default: irq_code = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/siocr_ram.sv
// ----------------------------------------------------------------------------
// siocr_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data appears next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module siocr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/siocr_ctrl.sv
// ----------------------------------------------------------------------------
// siocr_ctrl: sequencer
// Runs the page-fill sweep after reset, then accepts one request, lets the
// page memory read settle and commits it into the result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module siocr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output siocr_pkg::siocr_cmd_t    cmd_o
);
  import siocr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [RAM_AW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, commit;

  localparam logic [RAM_AW-1:0] CNT_LAST = RAM_AW'(RAM_DEPTH - 1);

  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign commit = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + RAM_AW'(1);
        if (cnt_q == CNT_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (commit) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  // result slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.clear    = (state_q == ST_CLEAR);
  assign cmd_o.clr_addr = cnt_q;
  assign cmd_o.capture  = accept;
  assign cmd_o.commit   = commit;

  // checks
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted request did not start execution");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed result not presented");
  a_hold_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && out_valid_q && out_stall_i |=> (state_q == ST_EXEC))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: rtl/siocr_dp.sv
// ----------------------------------------------------------------------------
// siocr_dp: register space datapath
// Port decode, index/data registers, global registers, device page memory
// with write masks, and the decoded resource outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module siocr_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire siocr_pkg::siocr_cmd_t cmd_i,
  input  wire logic                  opcode_i,
  input  wire logic [15:0]           port_address_i,
  input  wire logic [7:0]            write_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [7:0]            cfg_data_i,
  output logic [7:0]                 read_data_o,
  output logic                       config_mode_o,
  output logic [15:0]                config_port_base_o,
  output logic [11:0]                floppy_base_o,
  output logic [11:0]                parallel_base_o,
  output logic [11:0]                serial0_base_o,
  output logic [11:0]                serial1_base_o,
  output logic [7:0]                 gpio_window_base_o,
  output logic [7:0]                 parallel_config_b_o,
  output logic [1:0]                 serial0_clock_select_o,
  output logic [1:0]                 serial1_clock_select_o,
  output logic                       serial_irq_shared_o
);
  import siocr_pkg::*;

  // captured request
  logic        op_q;
  logic [15:0] addr_q;
  logic [7:0]  wd_q;

  // control state and global registers
  logic       alt_mode_q;
  logic       cim_q, cim_d;
  logic [7:0] ridx_q, ridx_d, gidx_q, gidx_d;
  logic [7:0] g02_q, g02_d, g03_q, g03_d, g07_q, g07_d;
  logic [7:0] g22_q, g22_d, g23_q, g23_d, g24_q, g24_d;
  logic [7:0] g26_q, g26_d, g27_q, g27_d;
  logic [7:0] gx_q [5];
  logic [7:0] gx_d [5];
  logic [7:0] rd_q, rd_d;

  // shadows of page registers that drive outputs
  logic [7:0] d0_30_q, d0_60_q, d0_61_q;
  logic [7:0] d3_30_q, d3_60_q, d3_61_q, d3_70_q, d3_74_q, d3_f0_q;
  logic [7:0] d4_30_q, d4_60_q, d4_61_q, d4_f0_q;
  logic [7:0] d5_30_q, d5_60_q, d5_61_q, d5_f0_q;

  // page memory
  logic              ram_we;
  logic [RAM_AW-1:0] ram_wa, ram_ra;
  logic [7:0]        ram_wd, ram_rd;
  logic              ex_we;
  logic [RAM_AW-1:0] ex_wa;
  logic [7:0]        ex_wd;

  siocr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  // decode helpers on current state
  logic [15:0] cb, cb_p1, gb16, gb16_p1;
  logic [7:0]  gb;
  logic        dev_ok;
  gpio_map_t   gm;
  dev_wr_t     dw;

  assign cb      = {g27_q, g26_q};
  assign cb_p1   = cb + 16'd1;
  assign gb      = (g03_q[7] || (alt_mode_q && cim_q)) ? gpio_base_of(g03_q[1:0]) : 8'h00;
  assign gb16    = {8'h00, gb};
  assign gb16_p1 = gb16 + 16'd1;
  assign dev_ok  = (32'(g07_q) <= LAST_DEVICE);
  assign gm      = gpio_map(gidx_q);
  assign dw      = dev_wr(g07_q[DEV_W-1:0], ridx_q);

  // read address: data register in config mode, GPIO window otherwise
  assign ram_ra = cim_q ? dev_addr(g07_q[DEV_W-1:0], ridx_q) : dev_addr(GPIO_DEV, gm.idx);

  // global register readback
  logic [7:0] glob_rd;
  always_comb begin
    case (ridx_q)
      8'h02: glob_rd = g02_q;
      8'h03: glob_rd = g03_q;
      8'h07: glob_rd = g07_q;
      8'h20: glob_rd = 8'h47;
      8'h21: glob_rd = 8'h01;
      8'h22: glob_rd = g22_q;
      8'h23: glob_rd = g23_q;
      8'h24: glob_rd = g24_q;
      8'h26: glob_rd = g26_q;
      8'h27: glob_rd = g27_q;
      8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F: glob_rd = gx_q[3'(ridx_q - 8'h2B)];
      default: glob_rd = 8'h00;
    endcase
  end

  // index and data read values
  logic [7:0] rr_index, rr_data;
  always_comb begin
    rr_index = cim_q ? ridx_q : 8'hFF;
    if (!cim_q) rr_data = 8'hFF;
    else if (ridx_q < 8'h30) rr_data = glob_rd;
    else if (!dev_ok || (g07_q == 8'h06 && ridx_q == 8'hF3)) rr_data = 8'hFF;
    else rr_data = ram_rd;
  end

  // request execution
  logic hit_fixed, hit_cfg, hit_gp, odd, rw_en, rw_idx, idx_rd;
  always_comb begin
    cim_d  = cim_q;
    ridx_d = ridx_q;
    gidx_d = gidx_q;
    g02_d  = g02_q;
    g03_d  = g03_q;
    g07_d  = g07_q;
    g22_d  = g22_q;
    g23_d  = g23_q;
    g24_d  = g24_q;
    g26_d  = g26_q;
    g27_d  = g27_q;
    gx_d   = gx_q;
    ex_we  = 1'b0;
    ex_wa  = dev_addr(g07_q[DEV_W-1:0], ridx_q);
    ex_wd  = (wd_q & dw.mask) | dw.orv;
    rd_d   = 8'hFF;

    odd       = addr_q[0];
    hit_fixed = alt_mode_q && (addr_q == PORT_LOCK || addr_q == PORT_UNLOCK);
    hit_cfg   = !hit_fixed && !alt_mode_q && (cb != 16'h0000) &&
                (addr_q == cb || addr_q == cb_p1);
    hit_gp    = !hit_fixed && !hit_cfg && (gb != 8'h00) &&
                (addr_q == gb16 || addr_q == gb16_p1);
    rw_en     = op_q && (hit_cfg || (hit_gp && cim_q && alt_mode_q));
    rw_idx    = !odd;

    idx_rd = !odd;
    if (addr_q == PORT_EA || addr_q == PORT_LOCK || addr_q == PORT_UNLOCK) idx_rd = 1'b1;
    else if (addr_q == PORT_EB) idx_rd = 1'b0;

    // read value
    if (hit_fixed) rd_d = rr_index;
    else if (hit_cfg) rd_d = idx_rd ? rr_index : rr_data;
    else if (hit_gp) begin
      if (cim_q) rd_d = alt_mode_q ? (odd ? rr_data : rr_index) : 8'hFF;
      else if (!odd) rd_d = gidx_q;
      else rd_d = (gm.hit && GPIO_OK) ? ram_rd : 8'hFF;
    end
    if (op_q) rd_d = 8'hFF;

    // fixed lock / unlock
    if (hit_fixed && op_q) cim_d = (addr_q == PORT_UNLOCK);

    // plain GPIO window
    if (hit_gp && op_q && !cim_q) begin
      if (!odd) gidx_d = wd_q;
      else if (gm.hit && GPIO_OK) begin
        ex_we = 1'b1;
        ex_wa = dev_addr(GPIO_DEV, gm.idx);
        ex_wd = wd_q & gm.mask;
      end
    end

    // index / data register write
    if (rw_en) begin
      if (rw_idx) begin
        if (!alt_mode_q && wd_q == KEY_ENTER && !cim_q) cim_d = 1'b1;
        else if (cim_q) begin
          if (!alt_mode_q && wd_q == KEY_EXIT) cim_d = 1'b0;
          else ridx_d = wd_q;
        end
      end else if (cim_q) begin
        if (ridx_q >= 8'h30) begin
          if (dev_ok && dw.hit) begin
            ex_we = 1'b1;
            if (wd_q[0]) g22_d = g22_q | dw.en;
          end
        end else begin
          case (ridx_q)
            8'h02: begin
              g02_d = wd_q;
              if (wd_q == 8'h02) cim_d = 1'b0;
            end
            8'h03: g03_d = wd_q & 8'h83;
            8'h07: g07_d = wd_q;
            8'h26: g26_d = wd_q;
            8'h27: g27_d = wd_q;
            8'h22: g22_d = wd_q & 8'h39;
            8'h23: g23_d = wd_q & 8'h39;
            8'h24: g24_d = wd_q & 8'h4E;
            8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F: gx_d[3'(ridx_q - 8'h2B)] = wd_q;
            default: g02_d = g02_q;
          endcase
        end
      end
    end
  end

  // memory write port: fill sweep or committed write
  logic [DEV_W-1:0] clr_dev;
  assign clr_dev = DEV_W'(cmd_i.clr_addr >> 8);
  assign ram_we  = cmd_i.clear || (cmd_i.commit && ex_we);
  assign ram_wa  = cmd_i.clear ? cmd_i.clr_addr : ex_wa;
  assign ram_wd  = cmd_i.clear ? dev_default(clr_dev, cmd_i.clr_addr[7:0]) : ex_wd;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      addr_q <= port_address_i;
      wd_q   <= write_data_i;
    end
    if (cmd_i.commit) rd_q <= rd_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_mode_q <= 1'b0;
      cim_q      <= 1'b0;
      ridx_q     <= 8'h00;
      gidx_q     <= 8'h00;
      g02_q      <= 8'h00;
      g03_q      <= 8'h03;
      g07_q      <= 8'h00;
      g22_q      <= 8'h39;
      g23_q      <= 8'h00;
      g24_q      <= 8'h04;
      g26_q      <= 8'hF0;
      g27_q      <= 8'h03;
      for (int i = 0; i < 5; i++) gx_q[i] <= 8'h00;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ALT_MODE) alt_mode_q <= cfg_data_i[0];
      else if (cfg_index_i == CFG_ALT_PORT) g26_q <= cfg_data_i[0] ? 8'h70 : 8'hF0;
    end else if (cmd_i.commit) begin
      cim_q  <= cim_d;
      ridx_q <= ridx_d;
      gidx_q <= gidx_d;
      g02_q  <= g02_d;
      g03_q  <= g03_d;
      g07_q  <= g07_d;
      g22_q  <= g22_d;
      g23_q  <= g23_d;
      g24_q  <= g24_d;
      g26_q  <= g26_d;
      g27_q  <= g27_d;
      gx_q   <= gx_d;
    end
  end

  // page shadows follow committed writes
  logic sh_we;
  assign sh_we = cmd_i.commit && ex_we;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_30_q <= dev_default(4'd0, 8'h30);
      d0_60_q <= dev_default(4'd0, 8'h60);
      d0_61_q <= dev_default(4'd0, 8'h61);
      d3_30_q <= dev_default(4'd3, 8'h30);
      d3_60_q <= dev_default(4'd3, 8'h60);
      d3_61_q <= dev_default(4'd3, 8'h61);
      d3_70_q <= dev_default(4'd3, 8'h70);
      d3_74_q <= dev_default(4'd3, 8'h74);
      d3_f0_q <= dev_default(4'd3, 8'hF0);
      d4_30_q <= dev_default(4'd4, 8'h30);
      d4_60_q <= dev_default(4'd4, 8'h60);
      d4_61_q <= dev_default(4'd4, 8'h61);
      d4_f0_q <= dev_default(4'd4, 8'hF0);
      d5_30_q <= dev_default(4'd5, 8'h30);
      d5_60_q <= dev_default(4'd5, 8'h60);
      d5_61_q <= dev_default(4'd5, 8'h61);
      d5_f0_q <= dev_default(4'd5, 8'hF0);
    end else if (sh_we) begin
      if (ex_wa == dev_addr(4'd0, 8'h30)) d0_30_q <= ex_wd;
      if (ex_wa == dev_addr(4'd0, 8'h60)) d0_60_q <= ex_wd;
      if (ex_wa == dev_addr(4'd0, 8'h61)) d0_61_q <= ex_wd;
      if (ex_wa == dev_addr(4'd3, 8'h30)) d3_30_q <= ex_wd;
      if (ex_wa == dev_addr(4'd3, 8'h60)) d3_60_q <= ex_wd;
      if (ex_wa == dev_addr(4'd3, 8'h61)) d3_61_q <= ex_wd;
      if (ex_wa == dev_addr(4'd3, 8'h70)) d3_70_q <= ex_wd;
      if (ex_wa == dev_addr(4'd3, 8'h74)) d3_74_q <= ex_wd;
      if (ex_wa == dev_addr(4'd3, 8'hF0)) d3_f0_q <= ex_wd;
      if (ex_wa == dev_addr(4'd4, 8'h30)) d4_30_q <= ex_wd;
      if (ex_wa == dev_addr(4'd4, 8'h60)) d4_60_q <= ex_wd;
      if (ex_wa == dev_addr(4'd4, 8'h61)) d4_61_q <= ex_wd;
      if (ex_wa == dev_addr(4'd4, 8'hF0)) d4_f0_q <= ex_wd;
      if (ex_wa == dev_addr(4'd5, 8'h30)) d5_30_q <= ex_wd;
      if (ex_wa == dev_addr(4'd5, 8'h60)) d5_60_q <= ex_wd;
      if (ex_wa == dev_addr(4'd5, 8'h61)) d5_61_q <= ex_wd;
      if (ex_wa == dev_addr(4'd5, 8'hF0)) d5_f0_q <= ex_wd;
    end
  end

  // 8-byte aligned resource window
  function automatic logic [11:0] range8(input logic en, input logic [7:0] act,
                                         input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] p;
    p = {hi, lo} & 16'hFFF8;
    range8 = (en && act != 8'h00 && p >= 16'h0100 && p <= 16'h0FF8) ? p[11:0] : 12'h000;
  endfunction

  // parallel port window depends on mode
  logic [15:0] pmask, lp, lim;
  assign pmask = d3_f0_q[0] ? 16'hFFF8 : 16'hFFFC;
  assign lp    = {d3_60_q, d3_61_q} & pmask;
  assign lim   = 16'h0FFC & pmask;

  assign read_data_o            = rd_q;
  assign config_mode_o          = cim_q;
  assign config_port_base_o     = cb;
  assign floppy_base_o          = range8(g22_q[0], d0_30_q, d0_60_q, d0_61_q);
  assign parallel_base_o        = (g22_q[3] && d3_30_q != 8'h00 && lp >= 16'h0100 &&
                                   lp <= lim) ? lp[11:0] : 12'h000;
  assign serial0_base_o         = range8(g22_q[4], d4_30_q, d4_60_q, d4_61_q);
  assign serial1_base_o         = range8(g22_q[5], d5_30_q, d5_60_q, d5_61_q);
  assign gpio_window_base_o     = gb;
  assign parallel_config_b_o    = irq_code(d3_70_q) |
                                  ((d3_74_q < 8'd4) ? d3_74_q : 8'h00);
  assign serial0_clock_select_o = d4_f0_q[1:0];
  assign serial1_clock_select_o = d5_f0_q[1:0];
  assign serial_irq_shared_o    = d4_f0_q[7];

endmodule

`default_nettype wire

// File: rtl/super_io_config_register_space.sv
// ----------------------------------------------------------------------------
// super_io_config_register_space: plug-and-play configuration register space
// Decodes I/O port requests to the configuration and GPIO windows.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries one bus read or write:
//   opcode, port address and write byte. Result channel (out_valid_o /
//   out_stall_i) returns the read byte and the decoded resource bases as they
//   stand after the request.
//   Each request is taken in the idle state while the device page memory is
//   read, then merged and committed in the execute state; no new request is
//   taken until it is committed, and the commit waits while the result stalls.
//   After reset the block fills the device page memory with its defaults,
//   one entry a cycle (RAM_DEPTH entries, 2304 for nine pages), with
//   in_stall_o high; configuration writes are taken at any time on the
//   cfg_valid_i / cfg_ready_o port and must only be issued while idle.
//   A stalled result is held; one further request is accepted meanwhile and
//   waits in execution until the result slot frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module super_io_config_register_space (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [15:0] port_address_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  output logic             config_mode_o,
  output logic [15:0]      config_port_base_o,
  output logic [11:0]      floppy_base_o,
  output logic [11:0]      parallel_base_o,
  output logic [11:0]      serial0_base_o,
  output logic [11:0]      serial1_base_o,
  output logic [7:0]       gpio_window_base_o,
  output logic [7:0]       parallel_config_b_o,
  output logic [1:0]       serial0_clock_select_o,
  output logic [1:0]       serial1_clock_select_o,
  output logic             serial_irq_shared_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import siocr_pkg::*;

  siocr_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  siocr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  siocr_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .opcode_i               (opcode_i),
    .port_address_i         (port_address_i),
    .write_data_i           (write_data_i),
    .cfg_we_i               (cfg_valid_i & cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .read_data_o            (read_data_o),
    .config_mode_o          (config_mode_o),
    .config_port_base_o     (config_port_base_o),
    .floppy_base_o          (floppy_base_o),
    .parallel_base_o        (parallel_base_o),
    .serial0_base_o         (serial0_base_o),
    .serial1_base_o         (serial1_base_o),
    .gpio_window_base_o     (gpio_window_base_o),
    .parallel_config_b_o    (parallel_config_b_o),
    .serial0_clock_select_o (serial0_clock_select_o),
    .serial1_clock_select_o (serial1_clock_select_o),
    .serial_irq_shared_o    (serial_irq_shared_o)
  );

endmodule

`default_nettype wire
